[rtl/cpss_pkg.sv]
// Package: shared constants, codes and types for the code point substring search.
`timescale 1ns / 1ps
package cpss_pkg;

  // Field widths
  localparam int unsigned ActW  = 3;
  localparam int unsigned CpW   = 21;
  localparam int unsigned FromW = 16;
  localparam int unsigned PosW  = 11;

  // Default store depths
  localparam int unsigned HaystackDepthDef = 1024;
  localparam int unsigned NeedleDepthDef   = 64;

  // Command codes
  typedef enum logic [ActW-1:0] {
    ActClear        = 3'd0,
    ActAppendHay    = 3'd1,
    ActAppendNeedle = 3'd2,
    ActSearchFwd    = 3'd3,
    ActSearchBwd    = 3'd4
  } action_e;

  // Search sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StCmp
  } state_e;

endpackage

[rtl/cpss_ram.sv]
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module cpss_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/codepoint_substring_search_top.sv]
// Top level: code point substring search over a haystack and a needle memory.
`timescale 1ns / 1ps
// Usage:
//   Command channel: a word is taken at a rising edge with start_i high and
//   busy_o low. action_i selects clear, append to haystack, append to needle,
//   forward search or backward search; code_point_i and from_index_i go with it.
//   Clear and append leave busy_o low, so appends stream at one code point per
//   cycle. Appends beyond a store's capacity are dropped and set the sticky
//   truncated flag until the next clear.
//   A search that has candidates raises busy_o and walks both memories: each
//   compared code point takes a memory read (StRead) and then a compare (StCmp),
//   since the haystack and needle RAMs register their read data. An empty
//   needle, or a search that cannot match, answers in the cycle after
//   acceptance and leaves busy_o low.
//   Result channel: done_o is high for exactly one cycle with found_o,
//   position_o and truncated_o; the receiver cannot hold it off.
//   Reset clears both lengths, the flag and the sequencer; memory contents are
//   not cleared, since only entries below the lengths are ever read.
module codepoint_substring_search_top
  import cpss_pkg::*;
#(
  parameter int unsigned HAYSTACK_DEPTH = HaystackDepthDef,
  parameter int unsigned NEEDLE_DEPTH   = NeedleDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [ActW-1:0]  action_i,
  input  logic [CpW-1:0]   code_point_i,
  input  logic [FromW-1:0] from_index_i,
  output logic             done_o,
  output logic             found_o,
  output logic [PosW-1:0]  position_o,
  output logic             truncated_o
);

  localparam int unsigned HAW = $clog2(HAYSTACK_DEPTH);
  localparam int unsigned NAW = $clog2(NEEDLE_DEPTH);
  localparam int unsigned HLW = $clog2(HAYSTACK_DEPTH + 1);
  localparam int unsigned NLW = $clog2(NEEDLE_DEPTH + 1);
  localparam int unsigned CW0 = (HLW > FromW) ? HLW : FromW;
  localparam int unsigned CW  = (NLW > CW0) ? NLW : CW0;

  state_e         state_q, state_d;
  logic [HLW-1:0] hlen_q, hlen_d;
  logic [NLW-1:0] nlen_q, nlen_d;
  logic           ovf_q, ovf_d;
  logic [HLW-1:0] idx_q, idx_d;
  logic [NAW-1:0] k_q, k_d;
  logic [HLW-1:0] last_q, last_d;
  logic           fwd_q, fwd_d;
  logic           done_q, done_d;
  logic           found_q, found_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic           trunc_q, trunc_d;

  logic           accept;
  action_e        act;
  logic           hay_we, ndl_we;
  logic [HLW-1:0] hay_sum;
  logic [CpW-1:0] hay_rdata, ndl_rdata;
  logic [CW-1:0]  from_ext, hlen_ext, nlen_ext, last_ext, start_ext, startm1_ext;
  logic [CW-1:0]  idx_ext, k_ext;

  assign accept = start_i && (state_q == StIdle);
  assign act    = action_e'(action_i);

  // Widen operands to a common compare width
  assign from_ext    = CW'(from_index_i);
  assign hlen_ext    = CW'(hlen_q);
  assign nlen_ext    = CW'(nlen_q);
  assign last_ext    = hlen_ext - nlen_ext;
  assign start_ext   = (from_ext < hlen_ext) ? from_ext : hlen_ext;
  assign startm1_ext = start_ext - CW'(1);
  assign idx_ext     = CW'(idx_q);
  assign k_ext       = CW'(k_q);
  assign hay_sum     = idx_q + HLW'(k_q);

  cpss_ram #(
    .WIDTH (CpW),
    .DEPTH (HAYSTACK_DEPTH)
  ) u_hay_ram (
    .clk_i   (clk_i),
    .we_i    (hay_we),
    .waddr_i (hlen_q[HAW-1:0]),
    .wdata_i (code_point_i),
    .raddr_i (hay_sum[HAW-1:0]),
    .rdata_o (hay_rdata)
  );

  cpss_ram #(
    .WIDTH (CpW),
    .DEPTH (NEEDLE_DEPTH)
  ) u_ndl_ram (
    .clk_i   (clk_i),
    .we_i    (ndl_we),
    .waddr_i (nlen_q[NAW-1:0]),
    .wdata_i (code_point_i),
    .raddr_i (k_q),
    .rdata_o (ndl_rdata)
  );

  // Sequencer: decode commands, walk candidates, compare one code point per pass
  always_comb begin
    state_d = state_q;
    hlen_d  = hlen_q;
    nlen_d  = nlen_q;
    ovf_d   = ovf_q;
    idx_d   = idx_q;
    k_d     = k_q;
    last_d  = last_q;
    fwd_d   = fwd_q;
    done_d  = 1'b0;
    found_d = found_q;
    pos_d   = pos_q;
    trunc_d = trunc_q;
    hay_we  = 1'b0;
    ndl_we  = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (act)
            ActClear: begin
              hlen_d = '0;
              nlen_d = '0;
              ovf_d  = 1'b0;
            end
            ActAppendHay: begin
              if (hlen_q < HLW'(HAYSTACK_DEPTH)) begin
                hay_we = 1'b1;
                hlen_d = hlen_q + HLW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            ActAppendNeedle: begin
              if (nlen_q < NLW'(NEEDLE_DEPTH)) begin
                ndl_we = 1'b1;
                nlen_d = nlen_q + NLW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            ActSearchFwd: begin
              trunc_d = ovf_q;
              found_d = 1'b0;
              pos_d   = '0;
              if (nlen_q == '0) begin
                done_d = 1'b1;
                if (from_ext <= hlen_ext) begin
                  found_d = 1'b1;
                  pos_d   = from_ext[PosW-1:0];
                end
              end else if (nlen_ext > hlen_ext || from_ext > last_ext) begin
                done_d = 1'b1;
              end else begin
                idx_d   = from_ext[HLW-1:0];
                k_d     = '0;
                last_d  = last_ext[HLW-1:0];
                fwd_d   = 1'b1;
                state_d = StRead;
              end
            end
            ActSearchBwd: begin
              trunc_d = ovf_q;
              found_d = 1'b0;
              pos_d   = '0;
              if (nlen_q == '0) begin
                done_d  = 1'b1;
                found_d = 1'b1;
                pos_d   = start_ext[PosW-1:0];
              end else if (start_ext == '0 || nlen_ext > hlen_ext) begin
                done_d = 1'b1;
              end else begin
                idx_d   = (startm1_ext < last_ext) ? startm1_ext[HLW-1:0]
                                                   : last_ext[HLW-1:0];
                k_d     = '0;
                last_d  = last_ext[HLW-1:0];
                fwd_d   = 1'b0;
                state_d = StRead;
              end
            end
            default: begin
              // unused command codes: drop
            end
          endcase
        end
      end
      StRead: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (hay_rdata == ndl_rdata) begin
          if (k_ext == nlen_ext - CW'(1)) begin
            done_d  = 1'b1;
            found_d = 1'b1;
            pos_d   = idx_ext[PosW-1:0];
            state_d = StIdle;
          end else begin
            k_d     = k_q + NAW'(1);
            state_d = StRead;
          end
        end else begin
          k_d = '0;
          if (fwd_q) begin
            if (idx_q == last_q) begin
              done_d  = 1'b1;
              state_d = StIdle;
            end else begin
              idx_d   = idx_q + HLW'(1);
              state_d = StRead;
            end
          end else begin
            if (idx_q == '0) begin
              done_d  = 1'b1;
              state_d = StIdle;
            end else begin
              idx_d   = idx_q - HLW'(1);
              state_d = StRead;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      hlen_q  <= '0;
      nlen_q  <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hlen_q  <= hlen_d;
      nlen_q  <= nlen_d;
      ovf_q   <= ovf_d;
      done_q  <= done_d;
    end
  end

  // Hold search cursor and result word
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    k_q     <= k_d;
    last_q  <= last_d;
    fwd_q   <= fwd_d;
    found_q <= found_d;
    pos_q   <= pos_d;
    trunc_q <= trunc_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign done_o      = done_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;
  assign truncated_o = trunc_q;

`ifndef SYNTHESIS
  // Compare only follows a read issued the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCmp) |-> ($past(state_q) == StRead))
    else $error("compare without preceding read");

  // Haystack reads stay below the loaded length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (hay_sum < hlen_q))
    else $error("haystack read beyond length");

  // Needle reads stay below the loaded length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (NLW'(k_q) < nlen_q))
    else $error("needle read beyond length");

  // Lengths never exceed capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hlen_q <= HLW'(HAYSTACK_DEPTH)) && (nlen_q <= NLW'(NEEDLE_DEPTH)))
    else $error("store length past capacity");
`endif

endmodule

[test/tb_top.sv]
// Testbench for codepoint_substring_search_top: directed table, extremes and random sessions.
`timescale 1ns / 1ps
module tb_top;
  import cpss_pkg::*;

  localparam int HayDepth = HaystackDepthDef;
  localparam int NdlDepth = NeedleDepthDef;

  // Unused action codes, ignored by the block
  localparam logic [ActW-1:0] ActRsvdLo = 3'd5;
  localparam logic [ActW-1:0] ActRsvdHi = 3'd7;

  localparam logic [CpW-1:0]   CpAllOnes = 21'h1FFFFF;
  localparam logic [CpW-1:0]   CpMaxUni  = 21'h10FFFF;
  localparam logic [FromW-1:0] FromMax   = 16'hFFFF;

  localparam int WordsPerPhase = 80;
  localparam int NumPhases     = 4;
  // Sender idle percentage per phase; the result side cannot stall, so its phase runs flat out
  localparam int PhaseIdle [NumPhases] = '{0, 65, 0, 22};

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
    logic            truncated;
  } match_t;

  typedef struct packed {
    logic [ActW-1:0]  act;
    logic [CpW-1:0]   cp;
    logic [FromW-1:0] fi;
    logic             fixed;
    match_t           res;
  } stim_row_t;

  localparam int DirRows = 25;
  // Directed words; rows with fixed set carry their result, the rest go through the predictor
  localparam stim_row_t DirTab [DirRows] = '{
    '{ActSearchFwd,    21'h0,      16'd0,   1'b1, '{1'b1, 11'd0, 1'b0}},
    '{ActSearchBwd,    21'h0,      FromMax, 1'b1, '{1'b1, 11'd0, 1'b0}},
    '{ActSearchFwd,    21'h0,      FromMax, 1'b1, '{1'b0, 11'd0, 1'b0}},
    '{ActRsvdLo,       CpAllOnes,  FromMax, 1'b0, '0},
    '{ActAppendHay,    CpAllOnes,  16'd0,   1'b0, '0},
    '{ActAppendHay,    21'h0,      FromMax, 1'b0, '0},
    '{ActAppendHay,    CpMaxUni,   16'd0,   1'b0, '0},
    '{ActAppendHay,    CpAllOnes,  16'd0,   1'b0, '0},
    '{ActAppendHay,    21'h0,      16'd0,   1'b0, '0},
    '{ActAppendNeedle, CpAllOnes,  16'd0,   1'b0, '0},
    '{ActSearchFwd,    21'h0,      16'd0,   1'b0, '0},
    '{ActSearchFwd,    21'h0,      16'd1,   1'b0, '0},
    '{ActSearchBwd,    21'h0,      FromMax, 1'b0, '0},
    '{ActSearchBwd,    21'h0,      16'd3,   1'b0, '0},
    '{ActAppendNeedle, 21'h0,      16'd0,   1'b0, '0},
    '{ActSearchFwd,    21'h0,      16'd1,   1'b0, '0},
    '{ActSearchBwd,    21'h0,      16'd3,   1'b0, '0},
    '{ActSearchFwd,    21'h0,      FromMax, 1'b1, '{1'b0, 11'd0, 1'b0}},
    '{ActRsvdHi,       21'h0AAAAA, 16'h5555, 1'b0, '0},
    '{ActSearchFwd,    21'h0,      16'd4,   1'b0, '0},
    '{ActClear,        21'h155555, 16'hAAAA, 1'b0, '0},
    '{ActSearchBwd,    21'h0,      16'd5,   1'b1, '{1'b1, 11'd0, 1'b0}},
    '{ActAppendNeedle, 21'h0AAAAA, 16'd0,   1'b0, '0},
    '{ActSearchFwd,    21'h0,      16'd0,   1'b1, '{1'b0, 11'd0, 1'b0}},
    '{ActClear,        21'h0,      16'd0,   1'b0, '0}
  };

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             start_i      = 1'b0;
  logic [ActW-1:0]  action_i     = ActClear;
  logic [CpW-1:0]   code_point_i = '0;
  logic [FromW-1:0] from_index_i = '0;
  logic             busy_o;
  logic             done_o;
  logic             found_o;
  logic [PosW-1:0]  position_o;
  logic             truncated_o;

  // Predictor state
  logic [CpW-1:0] hay_mem [HayDepth];
  logic [CpW-1:0] ndl_mem [NdlDepth];
  int             hay_len    = 0;
  int             ndl_len    = 0;
  bit             trunc_flag = 1'b0;

  match_t pending_matches [$];
  int     errors     = 0;
  int     words_sent = 0;
  int     idle_pct   = 0;

  codepoint_substring_search_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .action_i    (action_i),
    .code_point_i(code_point_i),
    .from_index_i(from_index_i),
    .done_o      (done_o),
    .found_o     (found_o),
    .position_o  (position_o),
    .truncated_o (truncated_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Whole needle sits inside the haystack at pos and matches there
  function automatic bit needle_fits(input int pos);
    if (pos > hay_len || hay_len - pos < ndl_len) return 1'b0;
    for (int k = 0; k < ndl_len; k++) begin
      if (hay_mem[pos + k] !== ndl_mem[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the predictor by one word; return 1 when the word yields a result
  function automatic bit predict_search(input logic [ActW-1:0] act, input logic [CpW-1:0] cp,
                                        input logic [FromW-1:0] fi, output match_t res);
    bit has_res;
    int start_pos;
    has_res = 1'b0;
    res = '0;
    case (act)
      ActClear: begin
        hay_len = 0;
        ndl_len = 0;
        trunc_flag = 1'b0;
      end
      ActAppendHay: begin
        if (hay_len < HayDepth) begin
          hay_mem[hay_len] = cp;
          hay_len++;
        end else trunc_flag = 1'b1;
      end
      ActAppendNeedle: begin
        if (ndl_len < NdlDepth) begin
          ndl_mem[ndl_len] = cp;
          ndl_len++;
        end else trunc_flag = 1'b1;
      end
      ActSearchFwd: begin
        has_res = 1'b1;
        if (ndl_len == 0) begin
          if (int'(fi) <= hay_len) begin
            res.found = 1'b1;
            res.position = fi[PosW-1:0];
          end
        end else begin
          for (int i = int'(fi); i < hay_len && !res.found; i++) begin
            if (needle_fits(i)) begin
              res.found = 1'b1;
              res.position = i[PosW-1:0];
            end
          end
        end
      end
      ActSearchBwd: begin
        has_res = 1'b1;
        start_pos = (int'(fi) < hay_len) ? int'(fi) : hay_len;
        if (ndl_len == 0) begin
          res.found = 1'b1;
          res.position = start_pos[PosW-1:0];
        end else begin
          for (int i = start_pos; i > 0 && !res.found; i--) begin
            if (needle_fits(i - 1)) begin
              res.found = 1'b1;
              res.position = PosW'(i - 1);
            end
          end
        end
      end
      default: ;
    endcase
    res.truncated = trunc_flag;
    return has_res;
  endfunction

  function automatic logic [CpW-1:0] wide_cp();
    return CpW'($urandom());
  endfunction

  // Mostly a small alphabet above base so matches happen; now and then any 21-bit value
  function automatic logic [CpW-1:0] sym_cp(input logic [CpW-1:0] base, input int alpha);
    if ($urandom_range(9) == 0) return wide_cp();
    return base + CpW'($urandom_range(alpha - 1, 0));
  endfunction

  function automatic logic [FromW-1:0] search_from();
    if ($urandom_range(4) == 0) return FromW'($urandom());
    return FromW'($urandom_range(hay_len + 2, 0));
  endfunction

  // Drive one word, hold it until taken, then record its expected result
  task automatic issue(input logic [ActW-1:0] act, input logic [CpW-1:0] cp,
                       input logic [FromW-1:0] fi, input bit fixed = 1'b0,
                       input match_t fixed_res = '0);
    match_t res;
    bit     has_res;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i      <= 1'b1;
    action_i     <= act;
    code_point_i <= cp;
    from_index_i <= fi;
    // busy_o only moves at the rising edge, so its value here holds for the next edge
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    has_res = predict_search(act, cp, fi, res);
    if (has_res) pending_matches.insert(pending_matches.size(), fixed ? fixed_res : res);
    if (act <= ActSearchBwd) words_sent++;
    @(negedge clk_i);
  endtask

  // One random session: load a haystack and a needle, then search it a few times
  task automatic run_session();
    int             hay_n;
    int             ndl_n;
    int             n_search;
    int             pick;
    int             slice_at;
    int             alpha;
    logic [CpW-1:0] base;
    if (hay_len > 48 || ndl_len > 8 || $urandom_range(3) != 0)
      issue(ActClear, wide_cp(), FromW'($urandom()));
    base = wide_cp();
    base[2:0] = '0;
    if ($urandom_range(1) == 0) base = '0;
    alpha = $urandom_range(4, 1);
    hay_n = ($urandom_range(9) == 0) ? $urandom_range(40, 25) : $urandom_range(24, 0);
    for (int k = 0; k < hay_n; k++) issue(ActAppendHay, sym_cp(base, alpha), FromW'($urandom()));
    pick = $urandom_range(39);
    if (pick == 0) begin
      // overrun the needle store
      for (int k = 0; k <= NdlDepth; k++) issue(ActAppendNeedle, sym_cp(base, alpha), '0);
    end else if (pick < 20 && hay_len > 0) begin
      ndl_n = $urandom_range(4, 1);
      slice_at = $urandom_range(hay_len - 1, 0);
      for (int k = 0; k < ndl_n; k++) begin
        issue(ActAppendNeedle,
              (slice_at + k < hay_len) ? hay_mem[slice_at + k] : sym_cp(base, alpha),
              FromW'($urandom()));
      end
    end else begin
      ndl_n = $urandom_range(4, 0);
      for (int k = 0; k < ndl_n; k++) issue(ActAppendNeedle, sym_cp(base, alpha), '0);
    end
    n_search = $urandom_range(6, 1);
    for (int k = 0; k < n_search; k++) begin
      // sprinkle ignored codes and stray appends between searches
      if ($urandom_range(7) == 0)
        issue(ActW'($urandom_range(ActRsvdHi, ActRsvdLo)), wide_cp(), FromW'($urandom()));
      if ($urandom_range(11) == 0)
        issue($urandom_range(1) ? ActAppendHay : ActAppendNeedle, sym_cp(base, alpha), '0);
      issue($urandom_range(1) ? ActSearchFwd : ActSearchBwd, wide_cp(), search_from());
    end
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    match_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: result with none expected: found %0b position %0d truncated %0b",
                 $time, found_o, position_o, truncated_o);
        errors++;
      end else begin
        want = pending_matches.pop_front();
        if (found_o !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, found_o);
          errors++;
        end
        if (position_o !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position, position_o);
          errors++;
        end
        if (truncated_o !== want.truncated) begin
          $display("%0t: truncated expected %0b actual %0b", $time, want.truncated,
                   truncated_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int slice_at;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    for (int r = 0; r < DirRows; r++)
      issue(DirTab[r].act, DirTab[r].cp, DirTab[r].fi, DirTab[r].fixed, DirTab[r].res);

    // Fill the haystack past capacity, then search the full store
    for (int k = 0; k <= HayDepth; k++) issue(ActAppendHay, sym_cp('0, 2), FromW'($urandom()));
    issue(ActSearchFwd, '0, 16'd1024, 1'b1, '{1'b1, 11'd1024, 1'b1});
    issue(ActSearchFwd, '0, 16'd1025, 1'b1, '{1'b0, 11'd0, 1'b1});
    issue(ActSearchBwd, '0, FromMax, 1'b1, '{1'b1, 11'd1024, 1'b1});
    // Full needle copied from the haystack, plus one dropped append
    slice_at = $urandom_range(HayDepth - NdlDepth, 0);
    for (int k = 0; k < NdlDepth; k++) issue(ActAppendNeedle, hay_mem[slice_at + k], '0);
    issue(ActAppendNeedle, CpAllOnes, '0);
    issue(ActSearchFwd, '0, 16'd0);
    issue(ActSearchFwd, '0, FromW'(slice_at));
    issue(ActSearchFwd, '0, 16'd1000);
    issue(ActSearchBwd, '0, FromMax);
    issue(ActSearchBwd, '0, FromW'(slice_at + 1));
    issue(ActClear, '0, '0);

    // Random sessions under each idling phase
    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_pct = PhaseIdle[ph];
      slice_at = words_sent + WordsPerPhase;
      while (words_sent < slice_at) run_session();
    end

    // Drain outstanding results
    start_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Hard stop for a hung search
  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

[codepoint_substring_search_top.f]
rtl/cpss_pkg.sv
rtl/cpss_ram.sv
rtl/codepoint_substring_search_top.sv
test/tb_top.sv
